[rtl/core/glbr_pkg.sv]
package glbr_pkg;

    localparam int LINE_WIDTH  = 160;
    localparam int LINE_ROWS   = 16;
    localparam int GLYPH_COUNT = 256;
    localparam int GLYPH_W     = 8;
    localparam int GLYPH_H     = 16;

    localparam int LINE_DEPTH   = LINE_WIDTH * LINE_ROWS;
    localparam int LINE_ADDR_W  = $clog2(LINE_DEPTH);
    localparam int COL_W        = $clog2(LINE_WIDTH);
    localparam int ROW_W        = (LINE_ROWS > 1) ? $clog2(LINE_ROWS) : 1;
    localparam int GLYPH_DEPTH  = GLYPH_COUNT * GLYPH_H;
    localparam int GLYPH_ADDR_W = $clog2(GLYPH_DEPTH);
    localparam int GLYPH_ROWS   = (LINE_ROWS < GLYPH_H) ? LINE_ROWS : GLYPH_H;

    localparam logic [15:0] BAR_SCALE_RESET = 16'd48485;
    localparam int          BAR_DIVISOR     = 1000000;
    localparam int          BAR_LEN_W       = $clog2(LINE_WIDTH + 1);
    localparam logic [31:0] BAR_SAT         = 32'(LINE_WIDTH * BAR_DIVISOR);

    // 1000000 = 64 * 15625: drop six bits, then multiply by ceil(2^36 / 15625)
    // below saturation the product is under 2^28, so 22 bits remain
    localparam int          BAR_PRE_SHIFT   = 6;
    localparam int          BAR_DIV_IN_W    = 22;
    localparam int          BAR_RECIP_W     = 23;
    localparam logic [22:0] BAR_RECIP       = 23'd4398047;
    localparam int          BAR_RECIP_SHIFT = 36;
    localparam int          BAR_PROD_W      = BAR_DIV_IN_W + BAR_RECIP_W;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;

    typedef enum logic [2:0] {
        ACT_FILL  = 3'd0,
        ACT_GLYPH = 3'd1,
        ACT_BAR   = 3'd2,
        ACT_LOAD  = 3'd3,
        ACT_READ  = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_SAT,
        F_DIV,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_FILL,
        B_GREAD,
        B_GPIX,
        B_BAR,
        B_RREAD,
        B_DONE
    } t_back_state;

    typedef struct packed {
        t_action                action;
        logic                   reject;
        logic [BAR_LEN_W-1:0]   bar_len;
        logic [7:0]             char_code;
        logic [7:0]             start_x;
        logic [15:0]            fg_color;
        logic [15:0]            bg_color;
        logic [3:0]             glyph_row;
        logic [7:0]             glyph_bits;
        logic [3:0]             read_row;
        logic [7:0]             read_column;
    } t_entry;

    typedef struct packed {
        logic full;
        logic valid;
    } t_q_stat;

endpackage

[rtl/core/glbr_front.sv]
module glbr_front import glbr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_clearing,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_char_code,
    input  logic [7:0]  i_start_x,
    input  logic [15:0] i_fg_color,
    input  logic [15:0] i_bg_color,
    input  logic [15:0] i_bar_value,
    input  logic [3:0]  i_glyph_row,
    input  logic [7:0]  i_glyph_bits,
    input  logic [3:0]  i_read_row,
    input  logic [7:0]  i_read_column,
    input  t_q_stat     i_q_stat,
    output logic        o_q_push,
    output t_entry      o_q_data
);

    t_front_state r_state, n_state;
    logic [15:0]  r_bar_scale;
    logic [15:0]  r_value;
    logic [31:0]  r_rem;
    t_entry       r_ent;
    logic         accept;
    logic [BAR_DIV_IN_W-1:0] div_in;
    logic [BAR_PROD_W-1:0]   div_prod;

    assign accept   = i_in_valid && o_in_ready;
    assign div_in   = r_rem[BAR_PRE_SHIFT +: BAR_DIV_IN_W];
    assign div_prod = BAR_PROD_W'(div_in) * BAR_PROD_W'(BAR_RECIP);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_state = (t_action'(i_action) == ACT_BAR) ? F_MUL : F_PUSH;
                end
            end
            F_MUL:  n_state = F_SAT;
            F_SAT:  n_state = (r_rem >= BAR_SAT) ? F_PUSH : F_DIV;
            F_DIV:  n_state = F_PUSH;
            F_PUSH: begin
                if (!i_q_stat.full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_q_push   = 1'b0;
        unique case (r_state)
            F_IDLE: o_in_ready = !i_clearing;
            F_PUSH: o_q_push   = !i_q_stat.full;
            default: ;
        endcase
    end

    assign o_q_data = r_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= F_IDLE;
            r_bar_scale <= BAR_SCALE_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_bar_scale <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ent.action      <= t_action'(i_action);
            r_ent.reject      <= (32'(i_start_x) + GLYPH_W) > LINE_WIDTH;
            r_ent.bar_len     <= '0;
            r_ent.char_code   <= i_char_code;
            r_ent.start_x     <= i_start_x;
            r_ent.fg_color    <= i_fg_color;
            r_ent.bg_color    <= i_bg_color;
            r_ent.glyph_row   <= i_glyph_row;
            r_ent.glyph_bits  <= i_glyph_bits;
            r_ent.read_row    <= i_read_row;
            r_ent.read_column <= i_read_column;
            r_value           <= i_bar_value;
        end
        unique case (r_state)
            F_MUL: r_rem <= r_value * r_bar_scale;
            F_SAT: begin
                if (r_rem >= BAR_SAT) begin
                    r_ent.bar_len <= BAR_LEN_W'(LINE_WIDTH);
                end
            end
            // quotient by reciprocal multiplication
            F_DIV: r_ent.bar_len <= BAR_LEN_W'(div_prod >> BAR_RECIP_SHIFT);
            default: ;
        endcase
    end

endmodule

[rtl/core/glbr_queue.sv]
module glbr_queue import glbr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_entry  i_data,
    input  logic    i_pop,
    output t_entry  o_data,
    output t_q_stat o_stat
);

    t_entry             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr;
    logic [Q_PTR_W-1:0] r_rptr;
    logic [Q_PTR_W:0]   r_count;

    assign o_data       = r_mem[r_rptr];
    assign o_stat.full  = (32'(r_count) == Q_DEPTH);
    assign o_stat.valid = (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

[rtl/core/glbr_back.sv]
module glbr_back import glbr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_stat     i_q_stat,
    input  t_entry      i_q_data,
    output logic        o_q_pop,
    output logic        o_clearing,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_pixel,
    output logic        o_status,
    output logic [7:0]  o_bar_length
);

    t_back_state r_state, n_state;
    t_entry      r_ent;
    logic [LINE_ADDR_W-1:0] r_clr_addr;
    logic [ROW_W-1:0]       r_row;
    logic [COL_W-1:0]       r_col;
    logic [2:0]             r_gc;
    logic [7:0]             r_gdata;
    logic [15:0]            r_lrd;
    logic [15:0]            r_res_pixel;
    logic                   r_o_valid;
    logic [15:0]            r_o_pixel;
    logic                   r_o_status;
    logic [7:0]             r_o_bar;

    logic [15:0] line_mem  [LINE_DEPTH];
    logic [7:0]  glyph_mem [GLYPH_DEPTH];

    logic                   line_we;
    logic [LINE_ADDR_W-1:0] line_waddr;
    logic [15:0]            line_wdata;
    logic [LINE_ADDR_W-1:0] line_raddr;
    logic                   glyph_we;
    logic [GLYPH_ADDR_W-1:0] glyph_waddr;
    logic [GLYPH_ADDR_W-1:0] glyph_raddr;
    logic                   out_load;
    logic                   read_ok;
    logic                   last_col_fill;
    logic                   last_col_bar;
    logic                   last_row;
    logic                   last_glyph_row;
    logic [7:0]             gbits;
    logic [COL_W-1:0]       gcol;

    assign read_ok = (32'(i_q_data.read_row) < LINE_ROWS)
                  && (32'(i_q_data.read_column) < LINE_WIDTH);
    assign last_col_fill  = (32'(r_col) == LINE_WIDTH - 1);
    assign last_col_bar   = ((32'(r_col) + 1) == 32'(r_ent.bar_len));
    assign last_row       = (32'(r_row) == LINE_ROWS - 1);
    assign last_glyph_row = (32'(r_row) == GLYPH_ROWS - 1);
    // characters past the store draw as all background
    assign gbits = (32'(r_ent.char_code) < GLYPH_COUNT) ? r_gdata : 8'd0;
    assign gcol  = COL_W'(32'(r_ent.start_x) + 32'(r_gc));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_CLEAR: begin
                if (32'(r_clr_addr) == LINE_DEPTH - 1) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (i_q_stat.valid) begin
                    unique case (i_q_data.action)
                        ACT_FILL:  n_state = B_FILL;
                        ACT_GLYPH: n_state = i_q_data.reject ? B_DONE : B_GREAD;
                        ACT_BAR:   n_state = (i_q_data.bar_len == '0) ? B_DONE : B_BAR;
                        ACT_READ:  n_state = read_ok ? B_RREAD : B_DONE;
                        default:   n_state = B_DONE;
                    endcase
                end
            end
            B_FILL: begin
                if (last_col_fill && last_row) begin
                    n_state = B_DONE;
                end
            end
            B_BAR: begin
                if (last_col_bar && last_row) begin
                    n_state = B_DONE;
                end
            end
            B_GREAD: n_state = B_GPIX;
            B_GPIX: begin
                if (r_gc == 3'd7) begin
                    n_state = last_glyph_row ? B_DONE : B_GREAD;
                end
            end
            B_RREAD: n_state = B_DONE;
            B_DONE: begin
                if (!r_o_valid || i_out_ready) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop     = 1'b0;
        o_clearing  = 1'b0;
        line_we     = 1'b0;
        line_waddr  = LINE_ADDR_W'(32'(r_row) * LINE_WIDTH + 32'(r_col));
        line_wdata  = r_ent.fg_color;
        line_raddr  = LINE_ADDR_W'(32'(i_q_data.read_row) * LINE_WIDTH
                                   + 32'(i_q_data.read_column));
        glyph_we    = 1'b0;
        glyph_waddr = GLYPH_ADDR_W'(32'(i_q_data.char_code) * GLYPH_H
                                    + 32'(i_q_data.glyph_row));
        glyph_raddr = GLYPH_ADDR_W'(32'(r_ent.char_code) * GLYPH_H + 32'(r_row));
        out_load    = 1'b0;
        unique case (r_state)
            B_CLEAR: begin
                o_clearing = 1'b1;
                line_we    = 1'b1;
                line_waddr = r_clr_addr;
                line_wdata = 16'd0;
            end
            B_IDLE: begin
                o_q_pop  = i_q_stat.valid;
                glyph_we = i_q_stat.valid && (i_q_data.action == ACT_LOAD)
                        && (32'(i_q_data.char_code) < GLYPH_COUNT);
            end
            B_FILL, B_BAR: line_we = 1'b1;
            B_GPIX: begin
                line_we    = 1'b1;
                line_waddr = LINE_ADDR_W'(32'(r_row) * LINE_WIDTH + 32'(gcol));
                line_wdata = gbits[3'd7 - r_gc] ? r_ent.fg_color : r_ent.bg_color;
            end
            B_DONE: out_load = !r_o_valid || i_out_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (line_we) begin
            line_mem[line_waddr] <= line_wdata;
        end
        r_lrd <= line_mem[line_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (glyph_we) begin
            glyph_mem[glyph_waddr] <= i_q_data.glyph_bits;
        end
        r_gdata <= glyph_mem[glyph_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_CLEAR;
            r_clr_addr <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_ent       <= i_q_data;
                r_row       <= '0;
                r_col       <= '0;
                r_gc        <= '0;
                r_res_pixel <= '0;
            end
            B_FILL: begin
                r_col <= last_col_fill ? '0 : r_col + 1'b1;
                if (last_col_fill) begin
                    r_row <= r_row + 1'b1;
                end
            end
            B_BAR: begin
                r_col <= last_col_bar ? '0 : r_col + 1'b1;
                if (last_col_bar) begin
                    r_row <= r_row + 1'b1;
                end
            end
            B_GPIX: begin
                r_gc <= r_gc + 1'b1;
                if (r_gc == 3'd7) begin
                    r_row <= r_row + 1'b1;
                end
            end
            B_RREAD: r_res_pixel <= r_lrd;
            default: ;
        endcase
        if (out_load) begin
            r_o_pixel  <= r_res_pixel;
            r_o_status <= (r_ent.action == ACT_GLYPH) && r_ent.reject;
            r_o_bar    <= (r_ent.action == ACT_BAR) ? 8'(r_ent.bar_len) : 8'd0;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_pixel      = r_o_pixel;
    assign o_status     = r_o_status;
    assign o_bar_length = r_o_bar;

endmodule

[rtl/core/glyph_and_bar_line_renderer_core.sv]
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_ready    action, char_code, start_x, colors, bar,
//                                                 font row, read address
// out       output     o_out_valid / i_out_ready  pixel, status, bar_length
// cfg       input      i_cfg_wr_en                i_cfg_wr_data (bar_scale)
//
// fill writes all LINE_WIDTH*LINE_ROWS (2560) line pixels; glyph reads each font row
// from the glyph store and then writes its 8 pixels; bar writes rows*length pixels;
// load, read and reject write none. the line store write port takes one pixel a cycle.
// the front registers each word, then pushes it; a bar word first passes F_MUL, F_SAT and, unless saturated, F_DIV.
// after reset a clearing pass writes zero to all 2560 line pixels; no word is
// taken meanwhile. a two-word queue and an output register decouple the sides.
module glyph_and_bar_line_renderer_core import glbr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_char_code,
    input  logic [7:0]  i_start_x,
    input  logic [15:0] i_fg_color,
    input  logic [15:0] i_bg_color,
    input  logic [15:0] i_bar_value,
    input  logic [3:0]  i_glyph_row,
    input  logic [7:0]  i_glyph_bits,
    input  logic [3:0]  i_read_row,
    input  logic [7:0]  i_read_column,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_pixel,
    output logic        o_status,
    output logic [7:0]  o_bar_length
);

    t_q_stat q_stat;
    t_entry  q_in;
    t_entry  q_out;
    logic    q_push;
    logic    q_pop;
    logic    clearing;

    glbr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_clearing    (clearing),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_char_code   (i_char_code),
        .i_start_x     (i_start_x),
        .i_fg_color    (i_fg_color),
        .i_bg_color    (i_bg_color),
        .i_bar_value   (i_bar_value),
        .i_glyph_row   (i_glyph_row),
        .i_glyph_bits  (i_glyph_bits),
        .i_read_row    (i_read_row),
        .i_read_column (i_read_column),
        .i_q_stat      (q_stat),
        .o_q_push      (q_push),
        .o_q_data      (q_in)
    );

    glbr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_stat  (q_stat)
    );

    glbr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_stat     (q_stat),
        .i_q_data     (q_out),
        .o_q_pop      (q_pop),
        .o_clearing   (clearing),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pixel      (o_pixel),
        .o_status     (o_status),
        .o_bar_length (o_bar_length)
    );

    a_no_accept_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !o_in_ready)
        else $error("word accepted during line clearing pass");

    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("queue push while full");

    a_reject_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_pixel == 16'd0 && o_bar_length == 8'd0))
        else $error("rejected glyph result carries pixel or bar data");

    a_bar_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_bar_length) <= LINE_WIDTH))
        else $error("bar length above line width");

endmodule
